// ----- hdl/mhtfr_pkg.sv -----
package mhtfr_pkg;

    localparam int Entries = 64;
    localparam int IdxW    = 6;
    localparam int CntW    = 7;
    localparam int MacW    = 48;
    localparam int IpW     = 32;
    localparam int StampW  = 32;

    typedef enum logic [1:0] {
        OP_LOOKUP = 2'd0,
        OP_ADD    = 2'd1,
        OP_REMOVE = 2'd2,
        OP_NOP    = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        STAT_OK     = 2'd0,
        STAT_MISS   = 2'd1,
        STAT_EVICT  = 2'd2,
        STAT_UNUSED = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_HIT_READ,
        ST_OLDEST,
        ST_ALLOC,
        ST_INC,
        ST_WRITE,
        ST_RANK_READ,
        ST_RANK_DATA,
        ST_DEC,
        ST_DONE
    } state_t;

endpackage

// ----- hdl/mac_host_table_fifo_replace_top.sv -----
// MAC host learning table, 64 entries, insertion-order replacement.
// Input stream (s_*): s_tuser carries the opcode (lookup, add, remove);
// s_tdata carries mac, ip, entry_sel and now. One result word per input
// word leaves on the m_* stream: m_tuser carries the status, m_tdata the
// entry index, the stored ip and stamp on a hit, the evicted mac and the
// count of used entries.
// Lookups, adds and removes of a used entry sweep the rank memory one
// entry per cycle; an add into a full table sweeps it twice, first to find
// the oldest entry. A remove of an unused entry or an unknown opcode does
// not sweep. s_tready is high only while the sequencer is idle, so the
// block takes one word at a time.
// Reset empties the table: all valid bits clear, all 64 entries sit in the
// free FIFO in ascending order. No clearing pass is needed.
// The result sits in an output register; while the receiver stalls, the
// block still accepts and works one more word, then holds it until the
// output register frees up.
module mac_host_table_fifo_replace_top (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [119:0] s_tdata,   // mac[47:0], ip[79:48], entry_sel[85:80], now[117:86]
    input  logic [1:0]   s_tuser,   // opcode[1:0]
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata,   // entry_index[5:0], ip_found[37:6], stamp_found[69:38],
                                    // evicted_mac[117:70], used_count[124:118]
    output logic [1:0]   m_tuser    // status[1:0]
);
    import mhtfr_pkg::*;

    logic [MacW-1:0]   mac_mem   [Entries];
    logic [IpW-1:0]    ip_mem    [Entries];
    logic [StampW-1:0] stamp_mem [Entries];
    logic [IdxW-1:0]   rank_mem  [Entries];
    logic [IdxW-1:0]   free_mem  [Entries];

    state_t state_reg, state_next;

    logic [Entries-1:0] valid_reg, valid_next;
    logic [Entries-1:0] fwr_reg, fwr_next;
    logic [IdxW-1:0]    head_reg, head_next;
    logic [CntW-1:0]    fcnt_reg, fcnt_next;
    logic [CntW-1:0]    scan_reg, scan_next;
    logic               pv_reg, pv_next;
    logic [IdxW-1:0]    pidx_reg, pidx_next;

    logic [MacW-1:0]   mac_reg, mac_next;
    logic [IpW-1:0]    ip_reg, ip_next;
    logic [IdxW-1:0]   sel_reg, sel_next;
    logic [StampW-1:0] now_reg, now_next;

    logic              hit_reg, hit_next;
    logic [IdxW-1:0]   best_reg, best_next;
    logic [IdxW-1:0]   brank_reg, brank_next;
    logic [IdxW-1:0]   e_reg, e_next;
    logic [IdxW-1:0]   r_reg, r_next;

    status_t           rstat_reg, rstat_next;
    logic [IdxW-1:0]   ridx_reg, ridx_next;
    logic [IpW-1:0]    rip_reg, rip_next;
    logic [StampW-1:0] rstamp_reg, rstamp_next;
    logic [MacW-1:0]   revm_reg, revm_next;

    logic              m_tvalid_reg, m_tvalid_next;
    status_t           ostat_reg, ostat_next;
    logic [IdxW-1:0]   oidx_reg, oidx_next;
    logic [IpW-1:0]    oip_reg, oip_next;
    logic [StampW-1:0] ostamp_reg, ostamp_next;
    logic [MacW-1:0]   oevm_reg, oevm_next;
    logic [CntW-1:0]   oused_reg, oused_next;

    logic [IdxW-1:0]   rd_addr;
    logic [MacW-1:0]   rd_mac_reg;
    logic [IdxW-1:0]   rd_rank_reg;
    logic [IpW-1:0]    rd_ip_reg;
    logic [StampW-1:0] rd_stamp_reg;
    logic [IdxW-1:0]   fq_data_reg;
    logic              fq_wr_reg;
    logic [IdxW-1:0]   fq_addr_reg;

    logic              rank_we;
    logic [IdxW-1:0]   rank_waddr;
    logic [IdxW-1:0]   rank_wdata;
    logic              fifo_we;
    logic [IdxW-1:0]   fifo_waddr;
    logic [IdxW-1:0]   fifo_wdata;
    logic              tbl_we;

    logic              s_fire;
    logic              scan_end;
    logic              is_scan;
    logic              out_free;

    assign s_fire   = s_tvalid && s_tready;
    assign scan_end = (scan_reg == CntW'(Entries)) && !pv_reg;
    assign is_scan  = (state_reg == ST_LOOKUP) || (state_reg == ST_OLDEST) ||
                      (state_reg == ST_INC) || (state_reg == ST_DEC);
    assign out_free = !m_tvalid_reg || m_tready;
    assign rd_addr  = (state_reg == ST_RANK_READ) ? sel_reg : scan_reg[IdxW-1:0];

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = ostat_reg;
    assign m_tdata  = {3'b000, oused_reg, oevm_reg, ostamp_reg, oip_reg, oidx_reg};

    // Memories
    always_ff @(posedge aclk) begin
        if (tbl_we) begin
            mac_mem[e_reg]   <= mac_reg;
            ip_mem[e_reg]    <= ip_reg;
            stamp_mem[e_reg] <= now_reg;
        end
        if (rank_we) begin
            rank_mem[rank_waddr] <= rank_wdata;
        end
        if (fifo_we) begin
            free_mem[fifo_waddr] <= fifo_wdata;
        end
        rd_mac_reg   <= mac_mem[rd_addr];
        rd_rank_reg  <= rank_mem[rd_addr];
        rd_ip_reg    <= ip_mem[best_reg];
        rd_stamp_reg <= stamp_mem[best_reg];
        fq_data_reg  <= free_mem[head_reg];
        fq_wr_reg    <= fwr_reg[head_reg];
        fq_addr_reg  <= head_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            valid_reg    <= '0;
            fwr_reg      <= '0;
            head_reg     <= '0;
            fcnt_reg     <= CntW'(Entries);
            scan_reg     <= '0;
            pv_reg       <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            valid_reg    <= valid_next;
            fwr_reg      <= fwr_next;
            head_reg     <= head_next;
            fcnt_reg     <= fcnt_next;
            scan_reg     <= scan_next;
            pv_reg       <= pv_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pidx_reg   <= pidx_next;
        mac_reg    <= mac_next;
        ip_reg     <= ip_next;
        sel_reg    <= sel_next;
        now_reg    <= now_next;
        hit_reg    <= hit_next;
        best_reg   <= best_next;
        brank_reg  <= brank_next;
        e_reg      <= e_next;
        r_reg      <= r_next;
        rstat_reg  <= rstat_next;
        ridx_reg   <= ridx_next;
        rip_reg    <= rip_next;
        rstamp_reg <= rstamp_next;
        revm_reg   <= revm_next;
        ostat_reg  <= ostat_next;
        oidx_reg   <= oidx_next;
        oip_reg    <= oip_next;
        ostamp_reg <= ostamp_next;
        oevm_reg   <= oevm_next;
        oused_reg  <= oused_next;
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    unique case (opcode_t'(s_tuser))
                        OP_LOOKUP: state_next = ST_LOOKUP;
                        OP_ADD:    state_next = (fcnt_reg == '0) ? ST_OLDEST : ST_ALLOC;
                        OP_REMOVE: state_next = valid_reg[s_tdata[85:80]] ? ST_RANK_READ
                                                                          : ST_DONE;
                        default:   state_next = ST_DONE;
                    endcase
                end
            end
            ST_LOOKUP: begin
                if (scan_end) begin
                    state_next = hit_reg ? ST_HIT_READ : ST_DONE;
                end
            end
            ST_HIT_READ:  state_next = ST_DONE;
            ST_OLDEST:    state_next = scan_end ? ST_ALLOC : ST_OLDEST;
            ST_ALLOC:     state_next = ST_INC;
            ST_INC:       state_next = scan_end ? ST_WRITE : ST_INC;
            ST_WRITE:     state_next = ST_DONE;
            ST_RANK_READ: state_next = ST_RANK_DATA;
            ST_RANK_DATA: state_next = ST_DEC;
            ST_DEC:       state_next = scan_end ? ST_DONE : ST_DEC;
            ST_DONE:      state_next = out_free ? ST_IDLE : ST_DONE;
            default:      state_next = ST_IDLE;
        endcase
    end

    // Datapath and outputs
    always_comb begin
        valid_next    = valid_reg;
        fwr_next      = fwr_reg;
        head_next     = head_reg;
        fcnt_next     = fcnt_reg;
        scan_next     = '0;
        pv_next       = 1'b0;
        pidx_next     = pidx_reg;
        mac_next      = mac_reg;
        ip_next       = ip_reg;
        sel_next      = sel_reg;
        now_next      = now_reg;
        hit_next      = hit_reg;
        best_next     = best_reg;
        brank_next    = brank_reg;
        e_next        = e_reg;
        r_next        = r_reg;
        rstat_next    = rstat_reg;
        ridx_next     = ridx_reg;
        rip_next      = rip_reg;
        rstamp_next   = rstamp_reg;
        revm_next     = revm_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        ostat_next    = ostat_reg;
        oidx_next     = oidx_reg;
        oip_next      = oip_reg;
        ostamp_next   = ostamp_reg;
        oevm_next     = oevm_reg;
        oused_next    = oused_reg;
        rank_we       = 1'b0;
        rank_waddr    = pidx_reg;
        rank_wdata    = rd_rank_reg;
        fifo_we       = 1'b0;
        fifo_waddr    = head_reg;
        fifo_wdata    = e_reg;
        tbl_we        = 1'b0;

        // advance the shared sweep one entry per cycle
        if (is_scan) begin
            if (scan_reg != CntW'(Entries)) begin
                scan_next = scan_reg + 1'b1;
                pv_next   = 1'b1;
                pidx_next = scan_reg[IdxW-1:0];
            end else begin
                scan_next = scan_reg;
            end
        end

        unique case (state_reg)
            ST_IDLE: begin
                mac_next    = s_tdata[47:0];
                ip_next     = s_tdata[79:48];
                sel_next    = s_tdata[85:80];
                now_next    = s_tdata[117:86];
                hit_next    = 1'b0;
                best_next   = '0;
                brank_next  = '0;
                e_next      = '0;
                rstat_next  = STAT_MISS;
                ridx_next   = '0;
                rip_next    = '0;
                rstamp_next = '0;
                revm_next   = '0;
                if (opcode_t'(s_tuser) == OP_REMOVE) begin
                    ridx_next  = s_tdata[85:80];
                    rstat_next = STAT_UNUSED;
                end
            end
            ST_LOOKUP: begin
                if (pv_reg && valid_reg[pidx_reg] && rd_mac_reg == mac_reg &&
                    (!hit_reg || rd_rank_reg < brank_reg)) begin
                    hit_next   = 1'b1;
                    best_next  = pidx_reg;
                    brank_next = rd_rank_reg;
                end
            end
            ST_HIT_READ: begin
                rstat_next  = STAT_OK;
                ridx_next   = best_reg;
                rip_next    = rd_ip_reg;
                rstamp_next = rd_stamp_reg;
            end
            ST_OLDEST: begin
                rstat_next = STAT_EVICT;
                if (pv_reg && valid_reg[pidx_reg] && rd_rank_reg == IdxW'(Entries - 1)) begin
                    e_next    = pidx_reg;
                    revm_next = rd_mac_reg;
                end
            end
            ST_ALLOC: begin
                // reuse the oldest entry, or pop the free FIFO head
                if (rstat_reg == STAT_EVICT) begin
                    fifo_we          = 1'b1;
                    fifo_waddr       = head_reg;
                    fifo_wdata       = e_reg;
                    fwr_next[head_reg] = 1'b1;
                end else begin
                    rstat_next = STAT_OK;
                    e_next     = fq_wr_reg ? fq_data_reg : fq_addr_reg;
                    fcnt_next  = fcnt_reg - 1'b1;
                end
                head_next = head_reg + 1'b1;
            end
            ST_INC: begin
                if (pv_reg && valid_reg[pidx_reg] && pidx_reg != e_reg) begin
                    rank_we    = 1'b1;
                    rank_wdata = rd_rank_reg + 1'b1;
                end
            end
            ST_WRITE: begin
                tbl_we            = 1'b1;
                rank_we           = 1'b1;
                rank_waddr        = e_reg;
                rank_wdata        = '0;
                valid_next[e_reg] = 1'b1;
                ridx_next         = e_reg;
            end
            ST_RANK_READ: begin
            end
            ST_RANK_DATA: begin
                r_next              = rd_rank_reg;
                valid_next[sel_reg] = 1'b0;
                fifo_we             = 1'b1;
                fifo_waddr          = head_reg + fcnt_reg[IdxW-1:0];
                fifo_wdata          = sel_reg;
                fwr_next[head_reg + fcnt_reg[IdxW-1:0]] = 1'b1;
                fcnt_next           = fcnt_reg + 1'b1;
                rstat_next          = STAT_OK;
            end
            ST_DEC: begin
                if (pv_reg && valid_reg[pidx_reg] && rd_rank_reg > r_reg) begin
                    rank_we    = 1'b1;
                    rank_wdata = rd_rank_reg - 1'b1;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    ostat_next    = rstat_reg;
                    oidx_next     = ridx_reg;
                    oip_next      = rip_reg;
                    ostamp_next   = rstamp_reg;
                    oevm_next     = revm_reg;
                    oused_next    = CntW'(Entries) - fcnt_reg;
                end
            end
            default: begin
            end
        endcase
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fcnt_reg <= CntW'(Entries))
        else $error("free count above table size");

    a_count_sum: assert property (@(posedge aclk) disable iff (!aresetn)
        !(state_reg == ST_INC || state_reg == ST_WRITE) |->
        (($countones(valid_reg) + fcnt_reg) == Entries))
        else $error("valid entries and free count disagree");

    a_alloc_free: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_WRITE |-> (valid_reg[e_reg] == (rstat_reg == STAT_EVICT)))
        else $error("allocated entry in wrong use state");

    a_dec_freed: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_DEC |-> !valid_reg[sel_reg])
        else $error("removed entry still valid during rank update");

endmodule
